[rtl/tte_pkg.sv]
// Shared types and constants of the series trig evaluator.
package tte_pkg;

  // Term magnitude (Q32), series sum (signed Q32), divider widths
  localparam int TW  = 40;
  localparam int SW  = 44;
  localparam int QW  = SW + 32;
  localparam int DW  = SW;
  localparam int SQW = 64;
  localparam int STW = 7;
  localparam int MUL_SHR = 58 - TW;

  localparam logic [1:0] REQ_SIN = 2'd0;
  localparam logic [1:0] REQ_COS = 2'd1;
  localparam logic [1:0] REQ_TAN = 2'd2;
  localparam logic [1:0] REQ_COT = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIVZ = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic       CFG_SINE_TERMS   = 1'b0;
  localparam logic       CFG_SERIES_TERMS = 1'b1;
  localparam logic [7:0] SINE_TERMS_RST   = 8'd200;
  localparam logic [7:0] SERIES_TERMS_RST = 8'd10;

  localparam logic signed [47:0] RES_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] RES_MIN = 48'sh8000_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SINIT, S_ADD, S_MUL, S_DLD, S_DIV, S_SDONE, S_FDIV, S_FIN
  } state_t;

endpackage

[rtl/taylor_trig_evaluator.sv]
// Top level: sequential Maclaurin-series sine/cosine/tangent/cotangent unit.
//
// Pulse start while busy is low to request one function of in_angle (signed
// Q3.29 radians), selected by in_req_type (0 sin, 1 cos, 2 tan, 3 cot). busy
// stays high for the whole evaluation; the answer shows for exactly one
// cycle with out_valid high, in the same cycle busy drops, and is not held:
// the receiver must capture it then. out_result is signed Q16.32, out_status
// is 0 ok, 1 division by zero, 2 saturated. After the accepting edge the unit
// squares the angle and sets up the series; every term but the last then runs
// a bit-serial shift-add multiply and a restoring divide on the one shared
// multiply and divide datapath, and a wrap-up state ends each series; a zero
// term count skips the terms. Sine uses sine_terms (reset 200); cosine uses
// series_terms (reset 10). Tangent and cotangent run both series on
// series_terms, then a division of the two sums. Term counts above MAX_TERMS
// are clamped to it. Write sine_terms at index 0 and series_terms at index 1
// through the cfg channel; cfg_ready is low while a request is in flight.
module taylor_trig_evaluator #(
  parameter int MAX_TERMS = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [47:0] out_result,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int KW    = $clog2(MAX_TERMS + 1);
  localparam int CW    = (KW > 8) ? KW : 8;
  localparam int FW    = $clog2(2 * MAX_TERMS + 2);
  localparam int DEN_W = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);

  localparam int TW  = tte_pkg::TW;
  localparam int SW  = tte_pkg::SW;
  localparam int QW  = tte_pkg::QW;
  localparam int DW  = tte_pkg::DW;
  localparam int SQW = tte_pkg::SQW;
  localparam int STW = tte_pkg::STW;

  tte_pkg::state_t state_r, state_nxt;

  logic [7:0]           sine_terms_r, series_terms_r;
  logic [1:0]           op_r, op_nxt;
  logic                 phase_r, phase_nxt;     // tan/cot: 0 sine part, 1 cosine part
  logic                 odd_r, odd_nxt;         // 1 sine series, 0 cosine series
  logic                 neg_r, neg_nxt;
  logic [31:0]          mag_r, mag_nxt;
  logic [SQW-1:0]       sq_r, sq_nxt;
  logic [TW-1:0]        term_r, term_nxt;
  logic                 tneg_r, tneg_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [SW-1:0] s_r, s_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [KW-1:0]        cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [SQW-1:0]       acc_r, acc_nxt;
  logic [TW-1:0]        mpl_r, mpl_nxt;
  logic [DW:0]          rem_r, rem_nxt;
  logic [QW-1:0]        quo_r, quo_nxt;
  logic [DW-1:0]        dvs_r, dvs_nxt;
  logic [STW-1:0]       step_r, step_nxt;
  logic                 rneg_r, rneg_nxt;
  logic signed [47:0]   res_r, res_nxt;
  logic [1:0]           st_r, st_nxt;
  logic                 outv_r, outv_nxt;

  // Shared datapath: one shift-add multiply step, one restoring divide step
  logic [SQW:0]   mul_sum;
  logic [DW:0]    rem_sh, rem_sub;
  logic           dv_ge;
  logic [QW-1:0]  quo_step;

  // Per-term helpers
  logic [CW-1:0]        cfg_cnt;
  logic [KW-1:0]        cnt_clamp;
  logic [FW-1:0]        f1;
  logic signed [SW-1:0] num_s, den_s;
  logic [SW-1:0]        num_abs, den_abs;
  logic                 q_sat;

  assign busy       = (state_r != tte_pkg::S_IDLE);
  assign cfg_ready  = ~busy;
  assign out_valid  = outv_r;
  assign out_result = res_r;
  assign out_status = st_r;

  always_comb begin
    mul_sum  = {1'b0, acc_r} + (mpl_r[0] ? {1'b0, sq_r} : {(SQW + 1){1'b0}});
    rem_sh   = {rem_r[DW-1:0], quo_r[QW-1]};
    dv_ge    = (rem_sh >= {1'b0, dvs_r});
    rem_sub  = rem_sh - {1'b0, dvs_r};
    quo_step = {quo_r[QW-2:0], dv_ge};
  end

  always_comb begin
    cfg_cnt   = CW'((op_r == tte_pkg::REQ_SIN) ? sine_terms_r : series_terms_r);
    cnt_clamp = (cfg_cnt > CW'(MAX_TERMS)) ? KW'(MAX_TERMS) : KW'(cfg_cnt);
    f1        = FW'({k_r, 1'b0}) + (odd_r ? FW'(2) : FW'(1));
    // tan = sin/cos, cot = cos/sin
    num_s     = (op_r == tte_pkg::REQ_TAN) ? s_r : sum_r;
    den_s     = (op_r == tte_pkg::REQ_TAN) ? sum_r : s_r;
    num_abs   = num_s[SW-1] ? SW'(-num_s) : SW'(num_s);
    den_abs   = den_s[SW-1] ? SW'(-den_s) : SW'(den_s);
    q_sat     = rneg_r ? ((|quo_r[QW-1:48]) | (quo_r[47] & (|quo_r[46:0])))
                       : (|quo_r[QW-1:47]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tte_pkg::S_IDLE;
      outv_r         <= 1'b0;
      sine_terms_r   <= tte_pkg::SINE_TERMS_RST;
      series_terms_r <= tte_pkg::SERIES_TERMS_RST;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tte_pkg::CFG_SINE_TERMS) begin
          sine_terms_r <= cfg_data;
        end else begin
          series_terms_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;   phase_r <= phase_nxt; odd_r  <= odd_nxt;  neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;  sq_r    <= sq_nxt;    term_r <= term_nxt; tneg_r <= tneg_nxt;
    sum_r  <= sum_nxt;  s_r     <= s_nxt;     k_r    <= k_nxt;    cnt_r  <= cnt_nxt;
    den_r  <= den_nxt;  acc_r   <= acc_nxt;   mpl_r  <= mpl_nxt;  rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;  dvs_r   <= dvs_nxt;   step_r <= step_nxt; rneg_r <= rneg_nxt;
    res_r  <= res_nxt;  st_r    <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;     phase_nxt = phase_r; odd_nxt = odd_r;   neg_nxt = neg_r;
    mag_nxt = mag_r;   sq_nxt = sq_r;       term_nxt = term_r; tneg_nxt = tneg_r;
    sum_nxt = sum_r;   s_nxt = s_r;         k_nxt = k_r;       cnt_nxt = cnt_r;
    den_nxt = den_r;   acc_nxt = acc_r;     mpl_nxt = mpl_r;   rem_nxt = rem_r;
    quo_nxt = quo_r;   dvs_nxt = dvs_r;     step_nxt = step_r; rneg_nxt = rneg_r;
    res_nxt = res_r;   st_nxt = st_r;
    outv_nxt = 1'b0;

    case (state_r)
      tte_pkg::S_IDLE: begin
        if (start) begin
          op_nxt    = in_req_type;
          neg_nxt   = in_angle[31];
          mag_nxt   = in_angle[31] ? (32'd0 - in_angle) : in_angle;
          phase_nxt = 1'b0;
          odd_nxt   = (in_req_type != tte_pkg::REQ_COS);
          state_nxt = tte_pkg::S_SQ;
        end
      end
      tte_pkg::S_SQ: begin
        sq_nxt    = SQW'(mag_r) * SQW'(mag_r);
        state_nxt = tte_pkg::S_SINIT;
      end
      tte_pkg::S_SINIT: begin
        cnt_nxt   = cnt_clamp;
        term_nxt  = odd_r ? TW'({mag_r, 3'b000}) : TW'(64'h1_0000_0000);
        tneg_nxt  = odd_r & neg_r;
        sum_nxt   = '0;
        k_nxt     = '0;
        state_nxt = (cnt_clamp == '0) ? tte_pkg::S_SDONE : tte_pkg::S_ADD;
      end
      tte_pkg::S_ADD: begin
        sum_nxt = tneg_r ? (sum_r - SW'(term_r)) : (sum_r + SW'(term_r));
        den_nxt = DEN_W'(DEN_W'(f1) * DEN_W'(f1 + FW'(1)));
        if (k_r == cnt_r - KW'(1)) begin
          state_nxt = tte_pkg::S_SDONE;
        end else begin
          mpl_nxt   = term_r;
          acc_nxt   = '0;
          step_nxt  = '0;
          state_nxt = tte_pkg::S_MUL;
        end
      end
      tte_pkg::S_MUL: begin
        acc_nxt  = mul_sum[SQW:1];
        mpl_nxt  = mpl_r >> 1;
        step_nxt = step_r + STW'(1);
        if (step_r == STW'(TW - 1)) begin
          state_nxt = tte_pkg::S_DLD;
        end
      end
      tte_pkg::S_DLD: begin
        // (term * x^2) >> 58 = acc >> 18 after TW shift steps
        quo_nxt   = {acc_r[tte_pkg::MUL_SHR +: TW], {(QW - TW){1'b0}}};
        rem_nxt   = '0;
        dvs_nxt   = DW'(den_r);
        step_nxt  = '0;
        state_nxt = tte_pkg::S_DIV;
      end
      tte_pkg::S_DIV: begin
        rem_nxt  = dv_ge ? rem_sub : rem_sh;
        quo_nxt  = quo_step;
        step_nxt = step_r + STW'(1);
        if (step_r == STW'(TW - 1)) begin
          term_nxt  = quo_step[TW-1:0];
          tneg_nxt  = ~tneg_r;
          k_nxt     = k_r + KW'(1);
          state_nxt = tte_pkg::S_ADD;
        end
      end
      tte_pkg::S_SDONE: begin
        if (op_r == tte_pkg::REQ_SIN || op_r == tte_pkg::REQ_COS) begin
          res_nxt   = 48'(sum_r);
          st_nxt    = tte_pkg::STAT_OK;
          outv_nxt  = 1'b1;
          state_nxt = tte_pkg::S_IDLE;
        end else if (!phase_r) begin
          s_nxt     = sum_r;
          phase_nxt = 1'b1;
          odd_nxt   = 1'b0;
          state_nxt = tte_pkg::S_SINIT;
        end else if (den_s == '0) begin
          res_nxt   = num_s[SW-1] ? tte_pkg::RES_MIN : tte_pkg::RES_MAX;
          st_nxt    = tte_pkg::STAT_DIVZ;
          outv_nxt  = 1'b1;
          state_nxt = tte_pkg::S_IDLE;
        end else begin
          rneg_nxt  = num_s[SW-1] ^ den_s[SW-1];
          quo_nxt   = {num_abs, 32'd0};
          rem_nxt   = '0;
          dvs_nxt   = den_abs;
          step_nxt  = '0;
          state_nxt = tte_pkg::S_FDIV;
        end
      end
      tte_pkg::S_FDIV: begin
        rem_nxt  = dv_ge ? rem_sub : rem_sh;
        quo_nxt  = quo_step;
        step_nxt = step_r + STW'(1);
        if (step_r == STW'(QW - 1)) begin
          state_nxt = tte_pkg::S_FIN;
        end
      end
      tte_pkg::S_FIN: begin
        if (q_sat) begin
          res_nxt = rneg_r ? tte_pkg::RES_MIN : tte_pkg::RES_MAX;
          st_nxt  = tte_pkg::STAT_SAT;
        end else begin
          res_nxt = rneg_r ? (48'sd0 - $signed(quo_r[47:0])) : $signed(quo_r[47:0]);
          st_nxt  = tte_pkg::STAT_OK;
        end
        outv_nxt  = 1'b1;
        state_nxt = tte_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tte_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/tte_checker.sv]
// Port-level checker for the series trig evaluator, bound to the top level.
module tte_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [47:0] out_result,
  input logic [1:0]         out_status
);

  // An accepted request always raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // Result strobe comes as the unit goes idle, never twice in a row
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe while busy or repeated");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == tte_pkg::STAT_OK || out_status == tte_pkg::STAT_DIVZ ||
                   out_status == tte_pkg::STAT_SAT))
    else $error("undefined status code");

  // Divide by zero and saturation both pin the result to a limit
  a_flag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tte_pkg::STAT_OK |->
      (out_result == tte_pkg::RES_MAX || out_result == tte_pkg::RES_MIN))
    else $error("flagged result not at a limit");

endmodule

bind taylor_trig_evaluator tte_checker u_tte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_result (out_result),
  .out_status (out_status)
);

[test/tb_taylor_trig_evaluator.sv]
// Testbench for the series trig evaluator: directed table plus random requests.
`timescale 1ns / 1ps

module tb_taylor_trig_evaluator;

  localparam int MAX_TERMS = 255;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

  typedef struct {
    logic [47:0] res;
    logic [1:0]  st;
  } trig_answer_t;

  // Directed row: expected answer typed in only when known is set
  typedef struct {
    logic [1:0]  op;
    logic [31:0] ang;
    logic        known;
    logic [47:0] res;
    logic [1:0]  st;
  } trig_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_req_type;
  logic signed [31:0] in_angle;
  logic out_valid;
  logic signed [47:0] out_result;
  logic [1:0] out_status;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [7:0] cfg_data;

  // Local copy of the term-count registers
  logic [7:0] sine_count;
  logic [7:0] cos_count;

  trig_answer_t pending_answers[$];
  int errors;
  int answers_seen;
  int cycles;
  int op_hits[4];
  int status_hits[3];

  taylor_trig_evaluator #(.MAX_TERMS(MAX_TERMS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_angle(in_angle),
    .out_valid(out_valid), .out_result(out_result), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // (a * b) >> 58 over the full 128-bit product
  function automatic logic [63:0] mul_q58(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[121:58];
  endfunction

  // Maclaurin sum in signed Q32; odd picks the sine series
  function automatic logic [63:0] series_sum(logic [63:0] mag, logic neg,
                                             logic [7:0] count, logic odd);
    logic [63:0] sq, term, sum, f1, den;
    logic tneg;
    int n;
    sq = mag * mag;
    term = odd ? (mag << 3) : Q32_ONE;
    tneg = odd ? neg : 1'b0;
    sum = '0;
    n = (count > MAX_TERMS) ? MAX_TERMS : count;
    for (int k = 0; k < n; k++) begin
      sum = tneg ? sum - term : sum + term;
      f1 = odd ? 64'(2 * k + 2) : 64'(2 * k + 1);
      den = f1 * (f1 + 1);
      term = mul_q58(term, sq) / den;
      tneg = !tneg;
    end
    return sum;
  endfunction

  // Q32 quotient with divide-by-zero and saturation flags
  function automatic trig_answer_t quotient(logic [63:0] num, logic [63:0] den);
    trig_answer_t a;
    logic nneg, dneg, rneg, ovf;
    logic [63:0] n, d, q, r;
    logic [127:0] wide;
    nneg = num[63];
    dneg = den[63];
    n = nneg ? -num : num;
    d = dneg ? -den : den;
    if (d == 0) begin
      a.st = tte_pkg::STAT_DIVZ;
      a.res = nneg ? tte_pkg::RES_MIN : tte_pkg::RES_MAX;
      return a;
    end
    wide = {64'd0, n} << 32;
    q = '0;
    r = '0;
    ovf = 1'b0;
    for (int i = 127; i >= 0; i--) begin
      r = (r << 1) | 64'(wide[i]);
      if (q[47]) ovf = 1'b1;
      q = (q << 1) & ((64'd1 << 49) - 1);
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    rneg = nneg != dneg;
    if (ovf || q > (rneg ? (64'd1 << 47) : ((64'd1 << 47) - 1))) begin
      a.st = tte_pkg::STAT_SAT;
      a.res = rneg ? tte_pkg::RES_MIN : tte_pkg::RES_MAX;
      return a;
    end
    a.st = tte_pkg::STAT_OK;
    a.res = rneg ? 48'(-q) : q[47:0];
    return a;
  endfunction

  function automatic trig_answer_t predict_trig(logic [1:0] op, logic [31:0] ang);
    trig_answer_t a;
    logic neg;
    logic [63:0] mag, s, c, v;
    neg = ang[31];
    mag = neg ? (64'd1 << 32) - {32'd0, ang} : {32'd0, ang};
    a.st = tte_pkg::STAT_OK;
    case (op)
      tte_pkg::REQ_SIN: v = series_sum(mag, neg, sine_count, 1'b1);
      tte_pkg::REQ_COS: v = series_sum(mag, neg, cos_count, 1'b0);
      default: begin
        s = series_sum(mag, neg, cos_count, 1'b1);
        c = series_sum(mag, neg, cos_count, 1'b0);
        a = (op == tte_pkg::REQ_TAN) ? quotient(s, c) : quotient(c, s);
        return a;
      end
    endcase
    // Series sums fit, but clamp like the quotient path anyway
    if ($signed(v) > $signed(64'(tte_pkg::RES_MAX))) begin
      a.res = tte_pkg::RES_MAX;
      a.st = tte_pkg::STAT_SAT;
    end else if ($signed(v) < $signed(64'(tte_pkg::RES_MIN))) begin
      a.res = tte_pkg::RES_MIN;
      a.st = tte_pkg::STAT_SAT;
    end else begin
      a.res = v[47:0];
    end
    return a;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(15, 60);
  endfunction

  // Issue one request; predicted answer is queued at acceptance
  task automatic send_request(logic [1:0] op, logic [31:0] ang, logic known,
                              trig_answer_t typed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= op;
    in_angle <= ang;
    do @(posedge clk); while (busy);
    pending_answers.push_back(known ? typed : predict_trig(op, ang));
    op_hits[op]++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tte_pkg::CFG_SINE_TERMS) sine_count = val;
    else cos_count = val;
  endtask

  // Angles: full range, near zero, extremes, around plus and minus pi/2
  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: return 32'(843314857 + $signed($urandom_range(0, 2000)) - 1000)
                 ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic random_phase(logic [7:0] sines, logic [7:0] terms, int count);
    trig_answer_t none;
    none = '{default: '0};
    wait_idle();
    write_reg(tte_pkg::CFG_SINE_TERMS, sines);
    write_reg(tte_pkg::CFG_SERIES_TERMS, terms);
    cfg_valid <= 1'b0;
    for (int i = 0; i < count; i++)
      send_request(2'($urandom_range(0, 3)), pick_angle(), 1'b0, none);
  endtask

  // Result checker: every strobe must match the oldest pending answer
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result %h status %0d", out_result, out_status);
        errors++;
      end else begin
        trig_answer_t e;
        e = pending_answers.pop_front();
        answers_seen++;
        if (out_status <= tte_pkg::STAT_SAT) status_hits[out_status]++;
        if (out_result !== e.res) begin
          $error("result: expected %h actual %h", e.res, out_result);
          errors++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, out_status);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("taylor_trig_evaluator: mismatch");
      $finish;
    end
  end

  initial begin
    trig_row_t rows[20];
    trig_answer_t typed;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = tte_pkg::REQ_SIN;
    in_angle = '0;
    cfg_valid = 1'b0;
    cfg_index = tte_pkg::CFG_SINE_TERMS;
    cfg_data = '0;
    errors = 0;
    answers_seen = 0;
    cycles = 0;
    sine_count = tte_pkg::SINE_TERMS_RST;
    cos_count = tte_pkg::SERIES_TERMS_RST;

    // zero angle answers are exact; cotangent of zero divides by zero
    rows = '{
      '{tte_pkg::REQ_SIN, 32'h0, 1'b1, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COS, 32'h0, 1'b1, 48'h1_0000_0000, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_TAN, 32'h0, 1'b1, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COT, 32'h0, 1'b1, tte_pkg::RES_MAX, tte_pkg::STAT_DIVZ},
      '{tte_pkg::REQ_SIN, 32'h8000_0000, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_SIN, 32'h7FFF_FFFF, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_SIN, 32'h1, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COS, 32'h8000_0000, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COS, 32'h7FFF_FFFF, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COS, 32'd1686629713, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_TAN, 32'h8000_0000, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_TAN, 32'h7FFF_FFFF, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_TAN, 32'd843314857, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_TAN, -32'sd843314857, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COT, 32'h8000_0000, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COT, 32'h7FFF_FFFF, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_COT, 32'h1, 1'b0, 48'h0, tte_pkg::STAT_OK},         // saturates high
      '{tte_pkg::REQ_COT, 32'hFFFF_FFFF, 1'b0, 48'h0, tte_pkg::STAT_OK}, // saturates low
      '{tte_pkg::REQ_COT, 32'd1686629713, 1'b0, 48'h0, tte_pkg::STAT_OK},
      '{tte_pkg::REQ_TAN, 32'h0000_1000, 1'b0, 48'h0, tte_pkg::STAT_OK}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at reset term counts
    foreach (rows[i]) begin
      typed.res = rows[i].res;
      typed.st = rows[i].st;
      send_request(rows[i].op, rows[i].ang, rows[i].known, typed);
    end

    // Random requests over several term-count settings, extremes included
    random_phase(8'd1, 8'd0, 16);
    random_phase(8'($urandom_range(2, 20)), 8'($urandom_range(1, 20)), 30);
    random_phase(8'd255, 8'd255, 6);
    random_phase(8'($urandom_range(1, 12)), 8'd1, 20);
    random_phase(8'($urandom_range(3, 30)), 8'($urandom_range(2, 30)), 30);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d answers: sin %0d cos %0d tan %0d cot %0d requests",
             answers_seen, op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("statuses ok %0d, divide-by-zero %0d, saturated %0d; %0d cycles",
             status_hits[0], status_hits[1], status_hits[2], cycles);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("taylor_trig_evaluator: match");
    end else begin
      $display("taylor_trig_evaluator: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tte_pkg.sv
rtl/taylor_trig_evaluator.sv
rtl/tte_checker.sv
test/tb_taylor_trig_evaluator.sv
